// ===== hw/rtl/stw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants
// Formats, register indexes and saturation helpers for the stereo width block.
// ----------------------------------------------------------------------------
package stw_pkg;

   localparam int SIG_W    = 32;  // band signal width
   localparam int DLY_W    = 40;  // delay term width
   localparam int COEF_W   = 32;  // Q2.30 coefficient width
   localparam int WID_W    = 16;  // Q4.12 width gain
   localparam int WID_FRAC = 12;
   localparam int MUL_W    = 33;  // shared multiplier operand width
   localparam int PROD_W   = 66;  // product and accumulator width
   localparam int ADDR_W   = 4;   // delay memory address
   localparam int BQ_W     = 3;   // biquad index
   localparam int IDX_W    = 8;   // register index width on the port

   localparam logic signed [PROD_W-1:0] SIG_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] SIG_MIN = -SIG_MAX - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] DLY_MAX = PROD_W'(64'sd549755813887);
   localparam logic signed [PROD_W-1:0] DLY_MIN = -DLY_MAX - PROD_W'(1);

   typedef enum logic [IDX_W-1:0] {
      CSR_LOW_B0     = 8'd0,
      CSR_LOW_B1     = 8'd1,
      CSR_HIGH_B0    = 8'd2,
      CSR_HIGH_B1    = 8'd3,
      CSR_FB_A1      = 8'd4,
      CSR_FB_A2      = 8'd5,
      CSR_LOW_WIDTH  = 8'd6,
      CSR_HIGH_WIDTH = 8'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] low_b0;
      logic signed [COEF_W-1:0] low_b1;
      logic signed [COEF_W-1:0] high_b0;
      logic signed [COEF_W-1:0] high_b1;
      logic signed [COEF_W-1:0] fb_a1;
      logic signed [COEF_W-1:0] fb_a2;
      logic [WID_W-1:0]         lo_gain;
      logic [WID_W-1:0]         hi_gain;
   } coef_type;

   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [PROD_W-1:0] v);
      if (v > SIG_MAX) return SIG_W'(SIG_MAX);
      if (v < SIG_MIN) return SIG_W'(SIG_MIN);
      return SIG_W'(v);
   endfunction

   function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [PROD_W-1:0] v);
      if (v > DLY_MAX) return DLY_W'(DLY_MAX);
      if (v < DLY_MIN) return DLY_W'(DLY_MIN);
      return DLY_W'(v);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/two_band_stereo_width.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_band_stereo_width: two-band crossover stereo widener
// Each stereo word is split per channel by LR4 low and high crossovers
// (eight biquads, delay terms in a 16 x 40 memory), each band's side signal
// is scaled by its width register, and the bands are summed and saturated.
// Each biquad steps through states P0, P1, Y, A1, A2, W2 on the single shared
// 33 x 33 multiplier and one-read, one-write delay memory; two width products
// and an output state follow. One word is in flight at a time; req_tready is
// high whenever the sequencer is idle, and a finished result waits in the
// output register while the next word is taken. The user must write
// coefficients through the csr port while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module two_band_stereo_width
   import stw_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata: left_in, right_in (low bits up), zero padded
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   input  wire logic                                 req_tlast,
   // rsp_tdata: left_out, right_out (low bits up), zero padded
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [IDX_W-1:0]                     csr_index,
   input  wire logic [COEF_W-1:0]                    csr_data
);
   localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

   coef_type                      coef_ff;
   logic                          rsp_valid_ff;
   logic [DATA_W-1:0]             rsp_data_ff;
   logic                          rsp_last_ff;

   logic                          busy, done, out_free, last_o;
   logic signed [SAMPLE_BITS-1:0] left_o, right_o;

   // config writes are always accepted and registered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.low_b0  <= '0;
         coef_ff.low_b1  <= '0;
         coef_ff.high_b0 <= '0;
         coef_ff.high_b1 <= '0;
         coef_ff.fb_a1   <= '0;
         coef_ff.fb_a2   <= '0;
         coef_ff.lo_gain <= WID_W'(4096);
         coef_ff.hi_gain <= WID_W'(4096);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOW_B0:     coef_ff.low_b0  <= csr_data;
            CSR_LOW_B1:     coef_ff.low_b1  <= csr_data;
            CSR_HIGH_B0:    coef_ff.high_b0 <= csr_data;
            CSR_HIGH_B1:    coef_ff.high_b1 <= csr_data;
            CSR_FB_A1:      coef_ff.fb_a1   <= csr_data;
            CSR_FB_A2:      coef_ff.fb_a2   <= csr_data;
            CSR_LOW_WIDTH:  coef_ff.lo_gain <= csr_data[WID_W-1:0];
            CSR_HIGH_WIDTH: coef_ff.hi_gain <= csr_data[WID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !busy;
   // output register frees when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;

   stw_seq #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && !busy),
      .left_in   (req_tdata[SAMPLE_BITS-1:0]),
      .right_in  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .last_in   (req_tlast),
      .coef      (coef_ff),
      .out_free  (out_free),
      .busy      (busy),
      .done      (done),
      .left_out  (left_o),
      .right_out (right_o),
      .last_out  (last_o)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= DATA_W'({right_o, left_o});
         rsp_last_ff <= last_o;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/stw_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stw_mul: shared registered multiplier
// One signed product per cycle, registered; raw and rounded views.
// ----------------------------------------------------------------------------
module stw_mul
   import stw_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 30
) (
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]      prod_raw,
   output logic signed [PROD_W-1:0]      prod_rnd
);
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a * op_b);
   end

   assign prod_raw = prod_ff;
   // round half up to the sample LSB
   assign prod_rnd = (prod_ff + HALF) >>> COEF_FRAC_BITS;
endmodule
`default_nettype wire

// ===== hw/rtl/stw_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stw_mem: biquad delay term memory
// 16 x 40 synchronous memory, one read and one write port, per-entry valid.
// ----------------------------------------------------------------------------
module stw_mem
   import stw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DLY_W-1:0]       rd_data,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic signed [DLY_W-1:0]  wr_data
);
   localparam int DEPTH = 1 << ADDR_W;

   logic signed [DLY_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]        vld_ff;
   logic signed [DLY_W-1:0] data_ff;
   logic                    hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         hit_ff <= vld_ff[rd_addr];
      end
   end

   // unwritten entries read as zero
   assign rd_data = hit_ff ? data_ff : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/stw_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stw_seq: biquad and width sequencer
// Steps eight biquads through the shared multiplier, then the width mix.
// ----------------------------------------------------------------------------
module stw_seq
   import stw_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SAMPLE_BITS-1:0] left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] right_in,
   input  wire logic                          last_in,
   input  wire coef_type                      coef,
   input  wire logic                          out_free,
   output logic                               busy,
   output logic                               done,
   output logic signed [SAMPLE_BITS-1:0]      left_out,
   output logic signed [SAMPLE_BITS-1:0]      right_out,
   output logic                               last_out
);
   localparam logic signed [PROD_W-1:0] OUT_MAX =
      (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] OUT_MIN = -OUT_MAX - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] OUT_RND = PROD_W'(1) <<< WID_FRAC;

   typedef enum logic [3:0] {
      S_IDLE, S_P0, S_P1, S_Y, S_A1, S_A2, S_W2, S_M1, S_M2, S_OUT
   } state_type;

   state_type                      state_ff;
   logic [BQ_W-1:0]                k_ff;
   logic signed [SAMPLE_BITS-1:0]  l_ff, r_ff;
   logic                           last_ff;
   logic signed [SIG_W-1:0]        x_ff, y_ff;
   logic signed [PROD_W-1:0]       p0_ff, p1_ff, wl_ff, base_ff;
   logic signed [DLY_W-1:0]        s1_ff, s2_ff;
   logic signed [SIG_W-1:0]        yb_ff [4];

   logic signed [MUL_W-1:0]        op_a, op_b;
   logic signed [PROD_W-1:0]       prod_raw, prod_rnd;
   logic [ADDR_W-1:0]              rd_addr, wr_addr;
   logic signed [DLY_W-1:0]        rd_data, wr_data;
   logic                           wr_en;
   logic signed [COEF_W-1:0]       b0, b1;
   logic [BQ_W-1:0]                k_nxt;
   logic signed [PROD_W-1:0]       wterm, tl, tr, ql, qr;

   assign b0    = k_ff[BQ_W-1] ? coef.high_b0 : coef.low_b0;
   assign b1    = k_ff[BQ_W-1] ? coef.high_b1 : coef.low_b1;
   assign k_nxt = k_ff + BQ_W'(1);

   always_comb begin
      op_a    = MUL_W'(b0);
      op_b    = MUL_W'(x_ff);
      rd_addr = {k_ff, 1'b0};
      wr_en   = 1'b0;
      wr_addr = {k_ff, 1'b0};
      wr_data = sat_dly(p1_ff - prod_rnd + PROD_W'(s2_ff));
      case (state_ff)
         S_P1: begin
            op_a    = MUL_W'(b1);
            rd_addr = {k_ff, 1'b1};
         end
         S_A1: begin
            op_a = MUL_W'(coef.fb_a1);
            op_b = MUL_W'(y_ff);
         end
         S_A2: begin
            op_a  = MUL_W'(coef.fb_a2);
            op_b  = MUL_W'(y_ff);
            wr_en = 1'b1;
         end
         S_W2: begin
            wr_en   = 1'b1;
            wr_addr = {k_ff, 1'b1};
            wr_data = sat_dly(p0_ff - prod_rnd);
         end
         S_M1: begin
            op_a = MUL_W'(yb_ff[0]) - MUL_W'(yb_ff[1]);
            op_b = MUL_W'({1'b0, coef.lo_gain});
         end
         // high band product is held while the result waits
         S_M2, S_OUT: begin
            op_a = MUL_W'(yb_ff[2]) - MUL_W'(yb_ff[3]);
            op_b = MUL_W'({1'b0, coef.hi_gain});
         end
         default: begin
         end
      endcase
   end

   // width mix: one rounding step, then clamp
   assign wterm = wl_ff + prod_raw;
   assign tl    = (base_ff + wterm + OUT_RND) >>> (WID_FRAC + 1);
   assign tr    = (base_ff - wterm + OUT_RND) >>> (WID_FRAC + 1);
   assign ql    = (tl > OUT_MAX) ? OUT_MAX : ((tl < OUT_MIN) ? OUT_MIN : tl);
   assign qr    = (tr > OUT_MAX) ? OUT_MAX : ((tr < OUT_MIN) ? OUT_MIN : tr);

   assign left_out  = SAMPLE_BITS'(ql);
   assign right_out = SAMPLE_BITS'(qr);
   assign last_out  = last_ff;
   assign busy      = (state_ff != S_IDLE);
   assign done      = (state_ff == S_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_P0;
                  k_ff     <= '0;
               end
            end
            S_P0: state_ff <= S_P1;
            S_P1: state_ff <= S_Y;
            S_Y:  state_ff <= S_A1;
            S_A1: state_ff <= S_A2;
            S_A2: state_ff <= S_W2;
            S_W2: begin
               k_ff     <= k_nxt;
               state_ff <= (k_ff == '1) ? S_M1 : S_P0;
            end
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         l_ff    <= left_in;
         r_ff    <= right_in;
         last_ff <= last_in;
         x_ff    <= SIG_W'(left_in);
      end
      if (state_ff == S_P1) begin
         p0_ff <= prod_rnd;
         s1_ff <= rd_data;
      end
      if (state_ff == S_Y) begin
         p1_ff <= prod_rnd;
         s2_ff <= rd_data;
         y_ff  <= sat_sig(p0_ff + PROD_W'(s1_ff));
      end
      if (state_ff == S_W2) begin
         if (k_ff[0]) begin
            yb_ff[k_ff[BQ_W-1:1]] <= y_ff;
         end
         if (k_nxt[0]) begin
            x_ff <= y_ff;
         end else begin
            x_ff <= k_nxt[1] ? SIG_W'(r_ff) : SIG_W'(l_ff);
         end
      end
      if (state_ff == S_M1) begin
         base_ff <= (PROD_W'(yb_ff[0]) + PROD_W'(yb_ff[1]) + PROD_W'(yb_ff[2])
                     + PROD_W'(yb_ff[3])) <<< WID_FRAC;
      end
      if (state_ff == S_M2) begin
         wl_ff <= prod_raw;
      end
   end

   stw_mul #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mul (
      .clock    (clock),
      .op_a     (op_a),
      .op_b     (op_b),
      .prod_raw (prod_raw),
      .prod_rnd (prod_rnd)
   );

   stw_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/stw_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stw_check: port-level checks
// Watches the stream ports of the stereo width block.
// ----------------------------------------------------------------------------
module stw_check #(
   parameter int DATA_W = 48
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast
);
   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // one word in flight: input closes after a word is taken
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while busy");

   // no result can appear the cycle after acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");
endmodule

bind two_band_stereo_width stw_check #(.DATA_W(((2*SAMPLE_BITS+7)/8)*8)) u_stw_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
